FILE: rtl/hjm_pkg.sv
package hjm_pkg;

  // Width of the raw heading field in centidegrees.
  localparam int HeadingWidth = 24;

  localparam int HdgWidth   = 16;
  localparam int DiffWidth  = 15;
  localparam int TickWidth  = 17;
  localparam int ThrWidth   = 15;
  localparam int HoldWidth  = 16;

  localparam logic [HdgWidth-1:0]  FullTurn = HdgWidth'(36000);
  localparam logic [HdgWidth-1:0]  HalfTurn = HdgWidth'(18000);
  localparam logic [TickWidth-1:0] TickMax  = TickWidth'(65536);

  // Reciprocal of a full turn, scaled by 2^RecipShift and rounded down. For any
  // magnitude below 2^31 the quotient estimate is low by at most one.
  localparam int RecipShift = 32;
  localparam int RecipWidth = 17;
  localparam logic [RecipWidth-1:0] RecipMult =
    RecipWidth'((64'd1 << RecipShift) / 64'd36000);

  // Magnitude is at most 2^(HeadingWidth-1), so the quotient stays below
  // 2^(HeadingWidth-16).
  localparam int QuotWidth = HeadingWidth - 15;
  localparam int ProdWidth = HeadingWidth + RecipWidth;
  localparam int RemWidth  = QuotWidth + HdgWidth;

  // Configuration register indexes.
  localparam logic RegThreshold = 1'b0;
  localparam logic RegHold      = 1'b1;

  localparam logic FuncHeading = 1'b0;
  localparam logic FuncTick    = 1'b1;

  typedef struct packed {
    logic                           func;
    logic signed [HeadingWidth-1:0] heading_cdeg;
    logic                           heading_valid;
  } in_req_t;

  typedef struct packed {
    logic                 jump_warn;
    logic                 heading_seen;
    logic [HdgWidth-1:0]  heading_now_cdeg;
    logic [DiffWidth-1:0] jump_diff_cdeg;
    logic [TickWidth-1:0] ticks_since_jump;
  } out_rsp_t;

  // Request after magnitude and quotient estimate.
  typedef struct packed {
    logic                    func;
    logic                    valid;
    logic                    neg;
    logic [HeadingWidth-1:0] mag;
    logic [QuotWidth-1:0]    quot;
  } hjm_quot_t;

  // Request with the heading reduced to one turn.
  typedef struct packed {
    logic                func;
    logic                valid;
    logic [HdgWidth-1:0] hdg;
  } hjm_hdg_t;

endpackage

FILE: rtl/heading_jump_monitor.sv
// Heading jump monitor.
// Requests enter on the input channel (in_valid_i / in_ready_o / in_req_i).
// A request is either a heading sample in signed centidegrees or a time tick.
// Every request produces exactly one response on the output channel
// (out_valid_o / out_ready_i / out_rsp_o) carrying the warning flag, the last
// normalized heading, the difference of the last jump and the tick count.
// After the input register, a request passes a register stage after the
// reciprocal multiply, one after the reduction to 0..35999 and the response
// register after the tracking logic. Throughput is one request per clock
// cycle unless the receiver stalls; every stage is a single pass.
// The threshold and hold time are written through the APB-style port at
// byte addresses 0 and 4 and may only be changed while the block is idle.
// Reset clears the pipeline, the tracking state and restores the register
// defaults (threshold 9000, hold 5000). When the receiver stalls, the
// response register holds its value and stages fill up behind it; the input
// channel drops ready only once every stage is occupied.
module heading_jump_monitor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hjm_pkg::in_req_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hjm_pkg::out_rsp_t  out_rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import hjm_pkg::*;

  logic [ThrWidth-1:0]  threshold_q;
  logic [HoldWidth-1:0] hold_q;
  logic                 reg_write;
  logic                 reg_sel;

  logic     hdg_valid;
  logic     hdg_ready;
  hjm_hdg_t hdg;

  // Byte offset bits are ignored; bit 2 selects the register.
  assign reg_sel   = paddr[2];
  assign reg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThrWidth'(9000);
      hold_q      <= HoldWidth'(5000);
    end else if (reg_write) begin
      case (reg_sel)
        RegThreshold: threshold_q <= pwdata[ThrWidth-1:0];
        RegHold:      hold_q      <= pwdata[HoldWidth-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegThreshold: prdata = 32'(threshold_q);
      RegHold:      prdata = 32'(hold_q);
      default:      prdata = '0;
    endcase
  end

  // Reduction of the raw heading to one full turn.
  hjm_wrap u_wrap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .hdg_valid_o (hdg_valid),
    .hdg_ready_i (hdg_ready),
    .hdg_o       (hdg)
  );

  // Jump detection, tick counting and the response register.
  hjm_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hdg_valid_i (hdg_valid),
    .hdg_ready_o (hdg_ready),
    .hdg_i       (hdg),
    .threshold_i (threshold_q),
    .hold_i      (hold_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // A warning can only be raised after a heading has been seen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.jump_warn |-> out_rsp_o.heading_seen)
    else $error("warning raised without any heading");

  // A warning is only shown inside the hold window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.jump_warn |->
      out_rsp_o.ticks_since_jump <= TickWidth'(hold_q))
    else $error("warning outside the hold window");

  // The reported heading is always reduced to one turn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.heading_now_cdeg < FullTurn)
    else $error("heading not reduced to one turn");

  // A stored jump difference never exceeds half a turn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.jump_diff_cdeg <= DiffWidth'(HalfTurn))
    else $error("jump difference above half a turn");

endmodule

FILE: rtl/hjm_wrap.sv
module hjm_wrap (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hjm_pkg::in_req_t in_req_i,
  output logic             hdg_valid_o,
  input  logic             hdg_ready_i,
  output hjm_pkg::hjm_hdg_t hdg_o
);
  import hjm_pkg::*;

  // Stage A holds the raw request, stage B the quotient estimate, stage C the
  // heading reduced to 0..35999.
  logic      a_vld_q, b_vld_q, c_vld_q;
  logic      a_rdy, b_rdy, c_rdy;
  in_req_t   a_q;
  hjm_quot_t b_d, b_q;
  hjm_hdg_t  c_d, c_q;

  logic [HeadingWidth-1:0] mag;
  logic [ProdWidth-1:0]    quot_prod;
  logic [RemWidth-1:0]     turns_prod;
  logic [RemWidth-1:0]     rem_full;
  logic [TickWidth-1:0]    rem_wide;
  logic [HdgWidth-1:0]     rem;

  assign c_rdy      = !c_vld_q || hdg_ready_i;
  assign b_rdy      = !b_vld_q || c_rdy;
  assign a_rdy      = !a_vld_q || b_rdy;
  assign in_ready_o = a_rdy;

  always_comb begin
    mag       = a_q.heading_cdeg[HeadingWidth-1] ? HeadingWidth'(-a_q.heading_cdeg)
                                                 : HeadingWidth'(a_q.heading_cdeg);
    quot_prod = ProdWidth'(mag) * ProdWidth'(RecipMult);
    b_d.func  = a_q.func;
    b_d.valid = a_q.heading_valid;
    b_d.neg   = a_q.heading_cdeg[HeadingWidth-1];
    b_d.mag   = mag;
    b_d.quot  = quot_prod[RecipShift +: QuotWidth];
  end

  always_comb begin
    turns_prod = RemWidth'(b_q.quot) * RemWidth'(FullTurn);
    rem_full   = RemWidth'(b_q.mag) - turns_prod;
    rem_wide   = rem_full[TickWidth-1:0];
    // The estimate may be one short, so one correction step finishes the job.
    if (rem_wide >= TickWidth'(FullTurn)) begin
      rem_wide = rem_wide - TickWidth'(FullTurn);
    end
    rem = rem_wide[HdgWidth-1:0];
    c_d.func  = b_q.func;
    c_d.valid = b_q.valid;
    c_d.hdg   = (b_q.neg && rem != '0) ? FullTurn - rem : rem;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      if (a_rdy) a_vld_q <= in_valid_i;
      if (b_rdy) b_vld_q <= a_vld_q;
      if (c_rdy) c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && in_valid_i) a_q <= in_req_i;
    if (b_rdy && a_vld_q) b_q <= b_d;
    if (c_rdy && b_vld_q) c_q <= c_d;
  end

  assign hdg_valid_o = c_vld_q;
  assign hdg_o       = c_q;

endmodule

FILE: rtl/hjm_track.sv
module hjm_track (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          hdg_valid_i,
  output logic                          hdg_ready_o,
  input  hjm_pkg::hjm_hdg_t             hdg_i,
  input  logic [hjm_pkg::ThrWidth-1:0]  threshold_i,
  input  logic [hjm_pkg::HoldWidth-1:0] hold_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output hjm_pkg::out_rsp_t             out_rsp_o
);
  import hjm_pkg::*;

  logic                 out_vld_q;
  out_rsp_t             rsp_d, rsp_q;
  logic                 fire;

  logic [HdgWidth-1:0]  last_q, last_d;
  logic                 seen_q, seen_d;
  logic                 latched_q, latched_d;
  logic [DiffWidth-1:0] diff_q, diff_d;
  logic [TickWidth-1:0] ticks_q, ticks_d;

  logic [HdgWidth-1:0]  abs_diff;
  logic [HdgWidth-1:0]  circ_diff;
  logic                 warn;

  assign hdg_ready_o = !out_vld_q || out_ready_i;
  assign fire        = hdg_valid_i && hdg_ready_o;

  always_comb begin
    abs_diff  = (hdg_i.hdg > last_q) ? hdg_i.hdg - last_q : last_q - hdg_i.hdg;
    circ_diff = (abs_diff > HalfTurn) ? FullTurn - abs_diff : abs_diff;

    last_d    = last_q;
    seen_d    = seen_q;
    latched_d = latched_q;
    diff_d    = diff_q;
    ticks_d   = ticks_q;

    if (hdg_i.func == FuncTick) begin
      if (ticks_q != TickMax) begin
        ticks_d = ticks_q + TickWidth'(1);
      end
    end else if (hdg_i.valid) begin
      if (seen_q && threshold_i != '0 && circ_diff > HdgWidth'(threshold_i)) begin
        latched_d = 1'b1;
        diff_d    = circ_diff[DiffWidth-1:0];
        ticks_d   = '0;
      end
      seen_d = 1'b1;
      last_d = hdg_i.hdg;
    end

    warn = latched_d && (ticks_d <= TickWidth'(hold_i));
    if (!warn) begin
      latched_d = 1'b0;
    end

    rsp_d.jump_warn        = warn;
    rsp_d.heading_seen     = seen_d;
    rsp_d.heading_now_cdeg = last_d;
    rsp_d.jump_diff_cdeg   = diff_d;
    rsp_d.ticks_since_jump = ticks_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      last_q    <= '0;
      seen_q    <= 1'b0;
      latched_q <= 1'b0;
      diff_q    <= '0;
      ticks_q   <= '0;
    end else begin
      if (hdg_ready_o) out_vld_q <= hdg_valid_i;
      if (fire) begin
        last_q    <= last_d;
        seen_q    <= seen_d;
        latched_q <= latched_d;
        diff_q    <= diff_d;
        ticks_q   <= ticks_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) rsp_q <= rsp_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = rsp_q;

endmodule
